FILE: rtl/psg_pkg.sv
package psg_pkg;

    localparam int MAX_LIMIT   = 256;
    localparam int MAX_RESULTS = 54;
    localparam int FIRST_PRIME = 2;

    localparam int LIM_W   = 9;                       // upper_limit / prime_value width
    localparam int CAND_W  = LIM_W + 1;               // candidate, room for m + 2p overshoot
    localparam int TDATA_W = ((LIM_W + 7) / 8) * 8;
    localparam int CNT_W   = $clog2(MAX_RESULTS + 1);

    // odd candidates only: entry k holds 2k+1
    localparam int MAP_DEPTH = MAX_LIMIT / 2 + 1;
    localparam int MAP_AW    = $clog2(MAP_DEPTH);

    typedef logic [LIM_W-1:0]  lim_t;
    typedef logic [CAND_W-1:0] cand_t;
    typedef logic [MAP_AW-1:0] map_addr_t;
    typedef logic [CNT_W-1:0]  cnt_t;

    typedef struct packed {
        lim_t value;
        logic valid;
        logic last;
    } res_t;

endpackage

FILE: rtl/prime_sieve_generator_unit.sv
// Sequence: bitmap clear, then a read and a check per odd sieving candidate, a write per marked
// multiple and one more step per sieving prime, then a read and a check per odd candidate scanned.
// A prime leaves once the next one is found; the final beat ends it.
// Throughput: one query at a time; the next limit is taken once the final beat is queued.
// The scan is set by the single read port of the bitmap RAM.
// Reset: async active low, clears control state; the bitmap is cleared at each query with a limit of 2 or more.
module prime_sieve_generator_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [psg_pkg::TDATA_W-1:0]   s_axis_tdata,  // [8:0] upper_limit
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [psg_pkg::TDATA_W-1:0]   m_axis_tdata,  // [8:0] prime_value
    output logic                          m_axis_tuser,  // [0] valid_res
    output logic                          m_axis_tlast
);
    import psg_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_CLEAR = 8'b0000_0010,
        S_PRD   = 8'b0000_0100,
        S_PCHK  = 8'b0000_1000,
        S_MARK  = 8'b0001_0000,
        S_SRD   = 8'b0010_0000,
        S_SCHK  = 8'b0100_0000,
        S_FLUSH = 8'b1000_0000
    } state_t;

    state_t    state_reg, state_next;
    lim_t      n_reg, n_next;
    cand_t     p_reg, p_next;
    cand_t     m_reg, m_next;
    map_addr_t clr_reg, clr_next;
    cnt_t      cnt_reg, cnt_next;
    lim_t      pend_reg, pend_next;
    logic      pend_ok_reg, pend_ok_next;

    logic                  accept;
    lim_t                  in_limit, n_sat;
    logic [2*CAND_W-1:0]   sq;
    logic                  sq_over;
    logic                  m_over;
    logic                  scan_done;

    logic      wr_en, wr_data, rd_data;
    map_addr_t wr_addr, rd_addr;

    logic      push, free;
    res_t      res;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign in_limit      = s_axis_tdata[LIM_W-1:0];
    assign n_sat         = (in_limit > LIM_W'(MAX_LIMIT)) ? LIM_W'(MAX_LIMIT) : in_limit;

    assign sq        = (2*CAND_W)'(p_reg) * (2*CAND_W)'(p_reg);
    assign sq_over   = sq > (2*CAND_W)'(n_reg);
    assign m_over    = m_reg > CAND_W'(n_reg);
    assign scan_done = (p_reg > CAND_W'(n_reg)) || (cnt_reg == CNT_W'(MAX_RESULTS));

    // read port always follows the candidate; held while stalled so the data holds too
    assign rd_addr = p_reg[MAP_AW:1];

    always_comb
    begin
        state_next   = state_reg;
        n_next       = n_reg;
        p_next       = p_reg;
        m_next       = m_reg;
        clr_next     = clr_reg;
        cnt_next     = cnt_reg;
        pend_next    = pend_reg;
        pend_ok_next = pend_ok_reg;
        wr_en        = 1'b0;
        wr_addr      = clr_reg;
        wr_data      = 1'b0;
        push         = 1'b0;
        res          = '{value: pend_reg, valid: pend_ok_reg, last: 1'b0};

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    n_next   = n_sat;
                    clr_next = '0;
                    if (n_sat < LIM_W'(FIRST_PRIME))
                    begin
                        pend_next    = '0;
                        pend_ok_next = 1'b0;
                        state_next   = S_FLUSH;
                    end
                    else
                    begin
                        state_next = S_CLEAR;
                    end
                end
            end
            S_CLEAR:
            begin
                wr_en    = 1'b1;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == MAP_AW'(MAP_DEPTH - 1))
                begin
                    p_next     = CAND_W'(3);
                    state_next = S_PRD;
                end
            end
            S_PRD:
            begin
                if (sq_over)
                begin
                    pend_next    = LIM_W'(FIRST_PRIME);
                    pend_ok_next = 1'b1;
                    cnt_next     = CNT_W'(1);
                    p_next       = CAND_W'(3);
                    state_next   = S_SRD;
                end
                else
                begin
                    state_next = S_PCHK;
                end
            end
            S_PCHK:
            begin
                if (rd_data)
                begin
                    p_next     = p_reg + CAND_W'(2);
                    state_next = S_PRD;
                end
                else
                begin
                    m_next     = sq[CAND_W-1:0];
                    state_next = S_MARK;
                end
            end
            S_MARK:
            begin
                if (m_over)
                begin
                    p_next     = p_reg + CAND_W'(2);
                    state_next = S_PRD;
                end
                else
                begin
                    wr_en   = 1'b1;
                    wr_addr = m_reg[MAP_AW:1];
                    wr_data = 1'b1;
                    m_next  = m_reg + (p_reg << 1);
                end
            end
            S_SRD:
            begin
                state_next = scan_done ? S_FLUSH : S_SCHK;
            end
            S_SCHK:
            begin
                if (rd_data)
                begin
                    p_next     = p_reg + CAND_W'(2);
                    state_next = S_SRD;
                end
                else if (free)
                begin
                    // a new prime releases the held one, which is therefore not the last
                    push       = 1'b1;
                    pend_next  = p_reg[LIM_W-1:0];
                    cnt_next   = cnt_reg + 1'b1;
                    p_next     = p_reg + CAND_W'(2);
                    state_next = S_SRD;
                end
            end
            S_FLUSH:
            begin
                res.last = 1'b1;
                if (free)
                begin
                    push       = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg       <= n_next;
        p_reg       <= p_next;
        m_reg       <= m_next;
        clr_reg     <= clr_next;
        pend_reg    <= pend_next;
        pend_ok_reg <= pend_ok_next;
    end

    psg_map_ram u_map (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    psg_out_reg u_out (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .res           (res),
        .free          (free),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // multiples of an odd prime stepped by 2p stay odd
    a_mark_odd: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MARK) && wr_en |-> m_reg[0])
        else $error("even multiple marked");

    a_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(MAX_RESULTS))
        else $error("result count over cap");

    a_mid_push: assert property (@(posedge clk) disable iff (!rst_n)
        push && !res.last |-> (state_reg == S_SCHK) && res.valid)
        else $error("non-final beat outside scan");

    a_accept_next: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_CLEAR) || (state_reg == S_FLUSH))
        else $error("bad state after accept");

endmodule

FILE: rtl/psg_map_ram.sv
module psg_map_ram (
    input  logic               clk,
    input  logic               wr_en,
    input  psg_pkg::map_addr_t wr_addr,
    input  logic               wr_data,
    input  psg_pkg::map_addr_t rd_addr,
    output logic               rd_data
);
    import psg_pkg::*;

    logic mem [MAP_DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

FILE: rtl/psg_out_reg.sv
module psg_out_reg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    input  psg_pkg::res_t                 res,
    output logic                          free,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [psg_pkg::TDATA_W-1:0]   m_axis_tdata,  // [8:0] prime_value, rest zero
    output logic                          m_axis_tuser,  // [0] valid_res
    output logic                          m_axis_tlast
);
    import psg_pkg::*;

    logic valid_reg;
    res_t res_reg;

    assign free = !valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (free)
        begin
            valid_reg <= push;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && free)
        begin
            res_reg <= res;
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = TDATA_W'(res_reg.value);
    assign m_axis_tuser  = res_reg.valid;
    assign m_axis_tlast  = res_reg.last;

endmodule

FILE: sim/prime_sieve_generator_unit_tb.sv
`timescale 1ns / 100ps

module prime_sieve_generator_unit_tb;

    import psg_pkg::*;

    // expected primes per query, checked beat by beat against the master side
    class prime_scoreboard;
        res_t primes_due[$];
        bit   odd_composite[0:MAX_LIMIT];
        int   errors;

        function new();
            errors = 0;
        endfunction

        function void note_limit(lim_t n);
            int   lim;
            int   p;
            int   m;
            res_t r;
            res_t found[$];
            lim = (n > MAX_LIMIT) ? MAX_LIMIT : int'(n);
            foreach (odd_composite[i])
                odd_composite[i] = 1'b0;
            if (lim < FIRST_PRIME)
            begin
                r.value = '0;
                r.valid = 1'b0;
                r.last  = 1'b1;
                primes_due = {primes_due, r};
                return;
            end
            for (p = 3; p * p <= lim; p += 2)
            begin
                if (!odd_composite[p])
                begin
                    for (m = p * p; m <= lim; m += 2 * p)
                        odd_composite[m] = 1'b1;
                end
            end
            r.value = lim_t'(FIRST_PRIME);
            r.valid = 1'b1;
            r.last  = 1'b0;
            found = {found, r};
            for (p = 3; p <= lim && found.size() < MAX_RESULTS; p += 2)
            begin
                if (!odd_composite[p])
                begin
                    r.value = lim_t'(p);
                    found = {found, r};
                end
            end
            foreach (found[i])
            begin
                r = found[i];
                r.last = (i == found.size() - 1);
                primes_due = {primes_due, r};
            end
        endfunction

        function void check_beat(logic [TDATA_W-1:0] data, logic user, logic tl);
            res_t want;
            if (primes_due.size() == 0)
            begin
                $display("%0t: unexpected beat data=%0d valid=%0b last=%0b",
                         $time, data, user, tl);
                errors++;
                return;
            end
            want = primes_due.pop_front();
            if (data !== TDATA_W'(want.value))
            begin
                $display("%0t: prime_value mismatch expected=%0d actual=%0d",
                         $time, want.value, data);
                errors++;
            end
            if (user !== want.valid)
            begin
                $display("%0t: valid_res mismatch expected=%0b actual=%0b",
                         $time, want.valid, user);
                errors++;
            end
            if (tl !== want.last)
            begin
                $display("%0t: last mismatch expected=%0b actual=%0b",
                         $time, want.last, tl);
                errors++;
            end
        endfunction
    endclass

    logic                clk = 1'b0;
    logic                rst_n;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [TDATA_W-1:0]  s_axis_tdata;
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    logic [TDATA_W-1:0]  m_axis_tdata;
    logic                m_axis_tuser;
    logic                m_axis_tlast;

    prime_scoreboard     sb;
    bit                  out_calm;

    prime_sieve_generator_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #4 clk = ~clk;

    // called at a falling edge; returns at the falling edge after the beat
    task send_limit(input lim_t n, input bit calm);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 14);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= TDATA_W'(n);
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sb.note_limit(n);
        @(negedge clk);
    endtask

    task drain_results();
        int gap;
        forever
        begin
            gap = out_calm ? 0 : $urandom_range(0, 14);
            if (gap > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
            while (!m_axis_tvalid)
                @(posedge clk);
            sb.check_beat(m_axis_tdata, m_axis_tuser, m_axis_tlast);
            @(negedge clk);
        end
    endtask

    initial
    begin
        lim_t directed[$];
        lim_t n;
        int   sel;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        rst_n         = 1'b0;
        out_calm      = 1'b0;
        sb = new();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        fork
            drain_results();
        join_none

        // empty answers, tiny limits, prime squares, bit extremes, saturation
        directed = '{9'd0, 9'd1, 9'd2, 9'd3, 9'd4, 9'd5, 9'd8, 9'd9, 9'd15, 9'd16,
                     9'd25, 9'd48, 9'd49, 9'd120, 9'd121, 9'd169, 9'd225, 9'd255,
                     9'd256, 9'd257, 9'd289, 9'd300, 9'd511, 9'd0, 9'd2};
        foreach (directed[i])
            send_limit(directed[i], 1'b0);

        for (int i = 0; i < 400; i++)
        begin
            out_calm = ((i / 50) % 3 == 1);
            sel = $urandom_range(0, 99);
            if (sel < 55)
                n = lim_t'($urandom_range(0, 40));
            else if (sel < 85)
                n = lim_t'($urandom_range(0, MAX_LIMIT));
            else
                n = lim_t'($urandom_range(MAX_LIMIT + 1, 511));
            send_limit(n, (i / 50) % 3 == 2);
        end
        s_axis_tvalid <= 1'b0;
        out_calm = 1'b0;

        while (sb.primes_due.size() != 0)
            @(posedge clk);
        repeat (700) @(posedge clk);
        if (sb.errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        #30_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
